FILE: rtl/sha1_pkg.sv
package sha1_pkg;

   // Block geometry.
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_BITS  = 8 * BLOCK_BYTES;
   localparam int HASH_WORDS  = 5;

   // Round count of one compression; the cycle after the last round adds into the hash.
   localparam logic [6:0] LAST_ROUND    = 7'd80;
   localparam logic [6:0] SCHED_ROUNDS  = 7'd16;
   localparam logic [5:0] LAST_BYTE_POS = 6'd63;
   localparam logic [2:0] LAST_WORD_NUM = 3'd4;

   // Padding marker byte.
   localparam logic [7:0] PAD_MARK = 8'h80;

   // Initial hash values.
   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

   // Round constants.
   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } sha1_req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        last_word;
   } sha1_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMPRESS,
      ST_OUTPUT
   } sha1_state_type;

   // Boolean function of one round, chosen by the round's group of twenty.
   function automatic logic [31:0] sha1_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
      logic [31:0] r;
      if (rnd < 7'd20) begin
         r = (b & c) | (~b & d);
      end else if (rnd < 7'd40) begin
         r = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         r = (b & c) | (b & d) | (c & d);
      end else begin
         r = b ^ c ^ d;
      end
      return r;
   endfunction

   // Additive constant of one round.
   function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
      logic [31:0] r;
      if (rnd < 7'd20) begin
         r = K0;
      end else if (rnd < 7'd40) begin
         r = K1;
      end else if (rnd < 7'd60) begin
         r = K2;
      end else begin
         r = K3;
      end
      return r;
   endfunction

endpackage

FILE: rtl/sha1_message_hasher_top.sv
// A byte beat is taken in the idle state; the beat that fills a 64-byte block starts a
// compression: 80 rounds of the shared round unit, then an add into the hash.
// No new byte is taken until that compression and any digest delivery are done.
// End of message: padding bytes go in one per cycle, then one or two compressions,
// then five result beats. Reset is synchronous and restores the initial hash values.
module sha1_message_hasher_top
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sha1_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sha1_rsp_type rsp_data
);

   sha1_state_type state_ff, state_in;

   logic [BLOCK_BITS-1:0] msg_ff, msg_in;
   logic [5:0]            pos_ff, pos_in;
   logic [63:0]           count_ff, count_in;
   logic [6:0]            rnd_ff, rnd_in;
   logic [2:0]            word_ff, word_in;
   logic [31:0]           a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]           a_in, b_in, c_in, d_in, e_in;
   logic [31:0]           h_ff [HASH_WORDS];
   logic [31:0]           h_in [HASH_WORDS];
   logic                  fin_ff, fin_in;
   logic                  sent80_ff, sent80_in;
   logic                  zfill_ff, zfill_in;
   logic                  lenblk_ff, lenblk_in;

   logic        req_fire;
   logic        byte_wr;
   logic [7:0]  byte_val;
   logic [7:0]  len_byte;
   logic [31:0] sched_w;
   logic [31:0] mix_w;

   assign req_fire = req_valid && req_ready;

   // Length bytes go out high byte first as the position walks 56 to 63.
   assign len_byte = count_ff[{~pos_ff[2:0], 3'b000} +: 8];

   // Schedule word of the current round, from fixed taps of the message shift line.
   assign mix_w   = msg_ff[BLOCK_BITS-1 -: 32] ^ msg_ff[BLOCK_BITS-65 -: 32]
                  ^ msg_ff[BLOCK_BITS-257 -: 32] ^ msg_ff[BLOCK_BITS-417 -: 32];
   assign sched_w = (rnd_ff < SCHED_ROUNDS) ? msg_ff[BLOCK_BITS-1 -: 32]
                                            : {mix_w[30:0], mix_w[31]};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.byte_present && pos_ff == LAST_BYTE_POS) begin
                  state_in = ST_COMPRESS;
               end else if (req_data.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (pos_ff == LAST_BYTE_POS) begin
               state_in = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            if (rnd_ff == LAST_ROUND) begin
               if (!fin_ff) begin
                  state_in = ST_IDLE;
               end else if (lenblk_ff) begin
                  state_in = ST_OUTPUT;
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready && word_ff == LAST_WORD_NUM) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Handshake outputs and result payload.
   always_comb begin
      req_ready            = (state_ff == ST_IDLE);
      rsp_valid            = (state_ff == ST_OUTPUT);
      rsp_data.digest_word = h_ff[word_ff];
      rsp_data.word_number = word_ff;
      rsp_data.last_word   = (word_ff == LAST_WORD_NUM);
   end

   // Datapath next values.
   always_comb begin
      msg_in    = msg_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      rnd_in    = rnd_ff;
      word_in   = word_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      d_in      = d_ff;
      e_in      = e_ff;
      h_in      = h_ff;
      fin_in    = fin_ff;
      sent80_in = sent80_ff;
      zfill_in  = zfill_ff;
      lenblk_in = lenblk_ff;
      byte_wr   = 1'b0;
      byte_val  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_data.byte_present) begin
                  byte_wr  = 1'b1;
                  byte_val = req_data.data_byte;
                  count_in = count_ff + 64'd8;
               end
               if (req_data.end_of_message) begin
                  fin_in = 1'b1;
               end
            end
         end
         ST_PAD: begin
            byte_wr = 1'b1;
            if (!sent80_ff) begin
               // Marker byte; past position 55 the length moves to an extra block.
               byte_val  = PAD_MARK;
               sent80_in = 1'b1;
               zfill_in  = (pos_ff[5:3] == 3'b111);
            end else if (!zfill_ff && pos_ff[5:3] == 3'b111) begin
               byte_val  = len_byte;
               lenblk_in = 1'b1;
            end
         end
         ST_COMPRESS: begin
            if (rnd_ff != LAST_ROUND) begin
               // One round of the shared unit; the schedule word rotates into the line.
               a_in   = {a_ff[26:0], a_ff[31:27]} + sha1_f(rnd_ff, b_ff, c_ff, d_ff)
                      + e_ff + sched_w + sha1_k(rnd_ff);
               b_in   = a_ff;
               c_in   = {b_ff[1:0], b_ff[31:2]};
               d_in   = c_ff;
               e_in   = d_ff;
               msg_in = {msg_ff[BLOCK_BITS-33:0], sched_w};
               rnd_in = rnd_ff + 7'd1;
            end else begin
               h_in[0]  = h_ff[0] + a_ff;
               h_in[1]  = h_ff[1] + b_ff;
               h_in[2]  = h_ff[2] + c_ff;
               h_in[3]  = h_ff[3] + d_ff;
               h_in[4]  = h_ff[4] + e_ff;
               rnd_in   = '0;
               zfill_in = 1'b0;
            end
         end
         ST_OUTPUT: begin
            if (rsp_ready) begin
               if (word_ff == LAST_WORD_NUM) begin
                  // Digest delivered: start the next message.
                  word_in   = '0;
                  h_in[0]   = H0_INIT;
                  h_in[1]   = H1_INIT;
                  h_in[2]   = H2_INIT;
                  h_in[3]   = H3_INIT;
                  h_in[4]   = H4_INIT;
                  count_in  = '0;
                  fin_in    = 1'b0;
                  sent80_in = 1'b0;
                  lenblk_in = 1'b0;
               end else begin
                  word_in = word_ff + 3'd1;
               end
            end
         end
         default: ;
      endcase

      // Byte path into the block, shared by message and padding bytes.
      if (byte_wr) begin
         msg_in = {msg_ff[BLOCK_BITS-9:0], byte_val};
         pos_in = pos_ff + 6'd1;
         if (pos_ff == LAST_BYTE_POS) begin
            a_in = h_ff[0];
            b_in = h_ff[1];
            c_in = h_ff[2];
            d_in = h_ff[3];
            e_in = h_ff[4];
         end
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= '0;
         count_ff  <= '0;
         rnd_ff    <= '0;
         word_ff   <= '0;
         fin_ff    <= 1'b0;
         sent80_ff <= 1'b0;
         zfill_ff  <= 1'b0;
         lenblk_ff <= 1'b0;
         h_ff[0]   <= H0_INIT;
         h_ff[1]   <= H1_INIT;
         h_ff[2]   <= H2_INIT;
         h_ff[3]   <= H3_INIT;
         h_ff[4]   <= H4_INIT;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         rnd_ff    <= rnd_in;
         word_ff   <= word_in;
         fin_ff    <= fin_in;
         sent80_ff <= sent80_in;
         zfill_ff  <= zfill_in;
         lenblk_ff <= lenblk_in;
         h_ff      <= h_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      msg_ff <= msg_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      e_ff   <= e_in;
   end

endmodule

FILE: rtl/sha1_checker.sv
module sha1_checker
   import sha1_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input sha1_rsp_type rsp_data
);

   // A stalled result beat holds its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");

   // The block takes no input while a digest is being delivered.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken during digest delivery");

   // Digest words follow one another in order without a gap.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
         rsp_valid && rsp_data.word_number == 3'($past(rsp_data.word_number) + 3'd1))
      else $error("digest word sequence broken");

   // The final word closes the digest and the block becomes ready again.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last_word |=> !rsp_valid && req_ready)
      else $error("digest did not end after the last word");

   // Only word four carries the last mark.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.last_word == (rsp_data.word_number == LAST_WORD_NUM))
      else $error("last mark on wrong word");

endmodule

bind sha1_message_hasher_top sha1_checker u_sha1_checker (.*);

FILE: tb/sv/tb_sha1_message_hasher_top.sv
`timescale 1ns / 1ps

module tb_sha1_message_hasher_top;
   import sha1_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 200;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   sha1_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   sha1_rsp_type rsp_data;

   sha1_message_hasher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Beats waiting to be sent, and digest words waiting to come back.
   sha1_req_type pending_q[$];
   sha1_rsp_type digest_q[$];

   // Shadow copy of the hasher state.
   logic [31:0] hash_acc [HASH_WORDS];
   logic [7:0]  blk_buf  [BLOCK_BYTES];
   logic [63:0] msg_bits;

   int unsigned fail_count     = 0;
   int unsigned beats_sent     = 0;
   int unsigned idle_beats     = 0;
   int unsigned msgs_hashed    = 0;
   int unsigned words_checked  = 0;
   int unsigned longest_msg    = 0;
   int unsigned cur_msg_len    = 0;
   int unsigned planned_items  = 0;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic void reset_hash_model();
      hash_acc[0] = H0_INIT;
      hash_acc[1] = H1_INIT;
      hash_acc[2] = H2_INIT;
      hash_acc[3] = H3_INIT;
      hash_acc[4] = H4_INIT;
      msg_bits    = 64'd0;
   endfunction

   // One 80-round compression of the shadow block buffer into the shadow hash.
   function automatic void compress_model();
      logic [31:0] a, b, c, d, e, f, k, t, wx;
      logic [31:0] sched [16];
      int r, s;
      a = hash_acc[0];
      b = hash_acc[1];
      c = hash_acc[2];
      d = hash_acc[3];
      e = hash_acc[4];
      for (r = 0; r < 16; r++) begin
         sched[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
      end
      for (r = 0; r < 80; r++) begin
         s = r % 16;
         if (r >= 16) begin
            wx = sched[(s + 13) % 16] ^ sched[(s + 8) % 16] ^ sched[(s + 2) % 16] ^ sched[s];
            sched[s] = rotl(wx, 1);
         end
         if (r < 20) begin
            f = (b & c) | (~b & d);
            k = K0;
         end else if (r < 40) begin
            f = b ^ c ^ d;
            k = K1;
         end else if (r < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K2;
         end else begin
            f = b ^ c ^ d;
            k = K3;
         end
         t = rotl(a, 5) + f + e + sched[s] + k;
         e = d;
         d = c;
         c = rotl(b, 30);
         b = a;
         a = t;
      end
      hash_acc[0] += a;
      hash_acc[1] += b;
      hash_acc[2] += c;
      hash_acc[3] += d;
      hash_acc[4] += e;
   endfunction

   // Appends the pad mark, zero fill and the big-endian bit length, and runs the final compressions.
   function automatic void pad_model();
      int idx, i;
      idx = int'(msg_bits[8:3]);
      blk_buf[idx] = PAD_MARK;
      idx = idx + 1;
      if (idx > 56) begin
         while (idx < BLOCK_BYTES) begin
            blk_buf[idx] = 8'h00;
            idx = idx + 1;
         end
         compress_model();
         idx = 0;
      end
      while (idx < 56) begin
         blk_buf[idx] = 8'h00;
         idx = idx + 1;
      end
      for (i = 0; i < 8; i++) begin
         blk_buf[56 + i] = msg_bits[63 - 8*i -: 8];
      end
      compress_model();
   endfunction

   // Updates the shadow state for one accepted beat and queues any digest words.
   function automatic void predict_digest(input sha1_req_type item);
      int pos, w;
      sha1_rsp_type exp_word;
      if (item.byte_present) begin
         pos = int'(msg_bits[8:3]);
         blk_buf[pos] = item.data_byte;
         msg_bits += 64'd8;
         cur_msg_len++;
         if (pos == int'(LAST_BYTE_POS)) begin
            compress_model();
         end
      end
      if (item.end_of_message) begin
         pad_model();
         for (w = 0; w < HASH_WORDS; w++) begin
            exp_word.digest_word = hash_acc[w];
            exp_word.word_number = 3'(w);
            exp_word.last_word   = (3'(w) == LAST_WORD_NUM);
            digest_q.push_back(exp_word);
         end
         reset_hash_model();
         msgs_hashed++;
         if (cur_msg_len > longest_msg) begin
            longest_msg = cur_msg_len;
         end
         cur_msg_len = 0;
      end
      if (!item.byte_present && !item.end_of_message) begin
         idle_beats++;
      end
   endfunction

   function automatic void push_req(input logic [7:0] d, input logic p, input logic e);
      sha1_req_type item;
      item.data_byte      = d;
      item.byte_present   = p;
      item.end_of_message = e;
      pending_q.push_back(item);
      planned_items++;
   endfunction

   // Queues a message of random bytes with occasional idle beats mixed in.
   function automatic void push_message(input int unsigned len, input bit end_on_byte);
      int unsigned i;
      for (i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) begin
            push_req(8'($urandom), 1'b0, 1'b0);
         end
         push_req(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
      end
      if (!end_on_byte || len == 0) begin
         push_req(8'($urandom), 1'b0, 1'b1);
      end
   endfunction

   // Driver: sends in bursts of random length separated by random gaps.
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left = $urandom_range(1, 20);
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_digest(req_data);
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
               req_data  <= pending_q.pop_front();
               req_valid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 20);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each digest word beat and drives a periodic stall pattern
   // whose period and duty are redrawn at the end of each stall epoch.
   int unsigned stall_period = 1;
   int unsigned stall_duty   = 0;
   int unsigned stall_phase  = 0;
   int unsigned stall_epoch  = 0;
   sha1_rsp_type exp_rsp;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_period = 1;
         stall_duty   = 0;
         stall_phase  = 0;
         stall_epoch  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_q.size() == 0) begin
               $error("unexpected digest beat: word %h number %0d last %0b",
                      rsp_data.digest_word, rsp_data.word_number, rsp_data.last_word);
               fail_count++;
            end else begin
               exp_rsp = digest_q.pop_front();
               words_checked++;
               if (rsp_data.digest_word !== exp_rsp.digest_word) begin
                  $error("digest_word mismatch: expected %h, actual %h",
                         exp_rsp.digest_word, rsp_data.digest_word);
                  fail_count++;
               end
               if (rsp_data.word_number !== exp_rsp.word_number) begin
                  $error("word_number mismatch: expected %0d, actual %0d",
                         exp_rsp.word_number, rsp_data.word_number);
                  fail_count++;
               end
               if (rsp_data.last_word !== exp_rsp.last_word) begin
                  $error("last_word mismatch: expected %0b, actual %0b",
                         exp_rsp.last_word, rsp_data.last_word);
                  fail_count++;
               end
            end
         end
         stall_epoch++;
         if (stall_epoch == 64) begin
            stall_epoch  = 0;
            stall_period = $urandom_range(1, 8);
            stall_duty   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, stall_period - 1);
            stall_phase  = 0;
         end
         stall_phase = (stall_phase + 1) % stall_period;
         rsp_ready <= (stall_phase >= stall_duty);
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Stimulus, reset and end of run.
   initial begin
      int unsigned len;
      reset_hash_model();

      // Empty message: only an empty final beat.
      push_req(8'h5C, 1'b0, 1'b1);
      // Three bytes with the end mark on the last byte.
      push_req(8'h61, 1'b1, 1'b0);
      push_req(8'h62, 1'b1, 1'b0);
      push_req(8'h63, 1'b1, 1'b1);
      // Extreme byte values, an idle beat inside the message, empty final beat.
      push_req(8'h00, 1'b1, 1'b0);
      push_req(8'hFF, 1'b1, 1'b0);
      push_req(8'hA3, 1'b0, 1'b0);
      push_req(8'hFF, 1'b1, 1'b0);
      push_req(8'h3A, 1'b0, 1'b1);
      // Single byte carrying the end mark, after an idle beat.
      push_req(8'hFF, 1'b0, 1'b0);
      push_req(8'h00, 1'b1, 1'b1);
      // Single byte followed by an empty final beat.
      push_req(8'h80, 1'b1, 1'b0);
      push_req(8'h00, 1'b0, 1'b1);

      // Random messages, mostly short, some at the padding and block boundaries.
      while (planned_items < 124) begin
         case ($urandom_range(0, 9))
            6: len = $urandom_range(55, 57);
            7: len = $urandom_range(63, 65);
            8: len = $urandom_range(118, 121);
            9: len = $urandom_range(9, 54);
            default: len = $urandom_range(0, 8);
         endcase
         // Keep the last message inside the item budget.
         if (planned_items + len + 1 > 132) begin
            len = 132 - planned_items - 1;
         end
         push_message(len, 1'($urandom_range(0, 1)));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock); while (pending_q.size() > 0 || req_valid);
      do @(negedge clock); while (digest_q.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (digest_q.size() != 0) begin
         $error("%0d digest words never arrived", digest_q.size());
         fail_count++;
      end

      $display("tb: %0d beats sent (%0d idle), %0d messages hashed, longest %0d bytes",
               beats_sent, idle_beats, msgs_hashed, longest_msg);
      $display("tb: %0d digest words checked, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
